[rtl/mos_pkg.sv]
`timescale 1ns / 1ps

package mos_pkg;

    localparam int PAGE_W    = 17;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_MEMORY_SIZE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAGE_LEN    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DATA_SIZE   = 2'd2;

    typedef logic [PAGE_W-1:0] page_off_t;

endpackage

[rtl/mos_in_stage.sv]
`timescale 1ns / 1ps

module mos_in_stage
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic allocated,
    input  logic advance,
    output logic s1_valid,
    output logic s1_alloc
);

    logic s1_valid_reg;
    logic s1_alloc_reg;

    assign in_ready = !s1_valid_reg || advance;
    assign s1_valid = s1_valid_reg;
    assign s1_alloc = s1_alloc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_alloc_reg <= allocated;
        end
    end

endmodule

[rtl/mos_scan_core.sv]
`timescale 1ns / 1ps

module mos_scan_core
#(
    parameter int ADDR_BITS = 20
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ADDR_BITS:0]     memory_size,
    input  mos_pkg::page_off_t     page_len,
    input  logic [ADDR_BITS:0]     data_size,
    input  logic                   s1_valid,
    input  logic                   s1_alloc,
    output logic                   advance,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   status,
    output logic                   any_set,
    output logic [ADDR_BITS-1:0]   first_address,
    output logic signed [ADDR_BITS:0] last_address,
    output logic [ADDR_BITS:0]     byte_count,
    output logic [ADDR_BITS:0]     fill_count,
    output logic [ADDR_BITS:0]     page_count,
    output logic [ADDR_BITS:0]     section_count,
    output logic [ADDR_BITS:0]     trailing_count
);

    localparam int CW = ADDR_BITS + 1;
    localparam int SW = (CW > mos_pkg::PAGE_W) ? CW : mos_pkg::PAGE_W;

    logic [CW-1:0]          byte_address_reg, byte_address_next;
    mos_pkg::page_off_t     page_offset_reg, page_offset_next;
    logic                   page_touched_reg, page_touched_next;
    logic                   in_run_reg, in_run_next;
    logic                   seen_any_reg, seen_any_next;
    logic [ADDR_BITS-1:0]   first_seen_reg, first_seen_next;
    logic [CW-1:0]          last_seen_reg, last_seen_next;
    logic [CW-1:0]          bytes_reg, bytes_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          pages_reg, pages_next;
    logic [CW-1:0]          sections_reg, sections_next;
    logic [CW-1:0]          trailing_reg, trailing_next;

    logic                   out_valid_reg;
    logic                   status_reg;
    logic                   any_set_reg;
    logic [ADDR_BITS-1:0]   first_address_reg;
    logic [CW-1:0]          last_address_reg;
    logic [CW-1:0]          byte_count_reg;
    logic [CW-1:0]          fill_count_reg;
    logic [CW-1:0]          page_count_reg;
    logic [CW-1:0]          section_count_reg;
    logic [CW-1:0]          trailing_count_reg;

    mos_pkg::page_off_t     pg_eff;
    mos_pkg::page_off_t     off_inc;
    logic [SW-1:0]          fill_sum;
    logic                   below;
    logic                   data_hit;
    logic                   is_last;
    logic                   size_err;

    assign pg_eff    = (page_len == '0) ? mos_pkg::page_off_t'(1) : page_len;
    assign off_inc   = page_offset_reg + mos_pkg::page_off_t'(1);
    assign below     = byte_address_reg < data_size;
    assign data_hit  = s1_alloc && below;
    assign fill_sum  = SW'(fill_reg) + SW'(page_offset_reg);
    assign byte_address_next = byte_address_reg + CW'(1);
    assign is_last   = (byte_address_next >= memory_size) || (byte_address_next == '0);
    assign size_err  = data_size > memory_size;
    assign advance   = s1_valid && (!is_last || !out_valid_reg || out_ready);

    always_comb
    begin
        seen_any_next     = seen_any_reg;
        first_seen_next   = first_seen_reg;
        last_seen_next    = last_seen_reg;
        in_run_next       = in_run_reg;
        page_touched_next = page_touched_reg;
        bytes_next        = bytes_reg;
        fill_next         = fill_reg;
        pages_next        = pages_reg;
        sections_next     = sections_reg;
        trailing_next     = trailing_reg;

        if (s1_alloc)
        begin
            if (!seen_any_reg)
            begin
                seen_any_next   = 1'b1;
                first_seen_next = byte_address_reg[ADDR_BITS-1:0];
            end
            last_seen_next = byte_address_reg;
        end

        if (data_hit)
        begin
            bytes_next = bytes_reg + CW'(1);
            if (!page_touched_reg)
            begin
                page_touched_next = 1'b1;
                fill_next         = fill_sum[CW-1:0];
                pages_next        = pages_reg + CW'(1);
            end
            if (!in_run_reg)
            begin
                in_run_next   = 1'b1;
                sections_next = sections_reg + CW'(1);
            end
        end
        else
        begin
            if (page_touched_reg)
            begin
                fill_next = fill_reg + CW'(1);
            end
            if (s1_alloc)
            begin
                trailing_next = trailing_reg + CW'(1);
            end
            else
            begin
                in_run_next = 1'b0;
            end
        end

        // wrap into the next page
        page_offset_next = off_inc;
        if (off_inc >= pg_eff)
        begin
            page_offset_next  = '0;
            page_touched_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_address_reg <= '0;
            page_offset_reg  <= '0;
            page_touched_reg <= 1'b0;
            in_run_reg       <= 1'b0;
            seen_any_reg     <= 1'b0;
            first_seen_reg   <= '0;
            last_seen_reg    <= '1;
            bytes_reg        <= '0;
            fill_reg         <= '0;
            pages_reg        <= '0;
            sections_reg     <= '0;
            trailing_reg     <= '0;
        end
        else if (advance)
        begin
            if (is_last)
            begin
                byte_address_reg <= '0;
                page_offset_reg  <= '0;
                page_touched_reg <= 1'b0;
                in_run_reg       <= 1'b0;
                seen_any_reg     <= 1'b0;
                first_seen_reg   <= '0;
                last_seen_reg    <= '1;
                bytes_reg        <= '0;
                fill_reg         <= '0;
                pages_reg        <= '0;
                sections_reg     <= '0;
                trailing_reg     <= '0;
            end
            else
            begin
                byte_address_reg <= byte_address_next;
                page_offset_reg  <= page_offset_next;
                page_touched_reg <= page_touched_next;
                in_run_reg       <= in_run_next;
                seen_any_reg     <= seen_any_next;
                first_seen_reg   <= first_seen_next;
                last_seen_reg    <= last_seen_next;
                bytes_reg        <= bytes_next;
                fill_reg         <= fill_next;
                pages_reg        <= pages_next;
                sections_reg     <= sections_next;
                trailing_reg     <= trailing_next;
            end
        end
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_last)
        begin
            status_reg <= size_err;
            if (size_err)
            begin
                any_set_reg        <= 1'b0;
                first_address_reg  <= '0;
                last_address_reg   <= '1;
                byte_count_reg     <= '0;
                fill_count_reg     <= '0;
                page_count_reg     <= '0;
                section_count_reg  <= '0;
                trailing_count_reg <= '0;
            end
            else
            begin
                any_set_reg        <= seen_any_next;
                first_address_reg  <= first_seen_next;
                last_address_reg   <= last_seen_next;
                byte_count_reg     <= bytes_next;
                fill_count_reg     <= fill_next;
                page_count_reg     <= pages_next;
                section_count_reg  <= sections_next;
                trailing_count_reg <= trailing_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign any_set        = any_set_reg;
    assign first_address  = first_address_reg;
    assign last_address   = last_address_reg;
    assign byte_count     = byte_count_reg;
    assign fill_count     = fill_count_reg;
    assign page_count     = page_count_reg;
    assign section_count  = section_count_reg;
    assign trailing_count = trailing_count_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last) |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten while waiting");

    a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last) |=> (byte_address_reg == '0 && !seen_any_reg))
        else $error("scan state not cleared after last byte");

    a_last_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_any_reg |-> (last_seen_reg == '1))
        else $error("last address set with no allocated byte");

    a_run_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
        in_run_reg |-> (seen_any_reg && sections_reg != '0))
        else $error("open section without any allocated byte");

    a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (byte_count_reg == '0 && !any_set_reg))
        else $error("error result carries counts");
`endif

endmodule

[rtl/memory_occupancy_stats_unit.sv]
`timescale 1ns / 1ps

// occupancy statistics over a stream of allocation tags, one word per byte in address
// order; one word is accepted every cycle unless words wait as told below; the word that
// ends the scan is registered in the input stage, then goes through the counter logic
// into the result register; a scan ends after memory_size words (one if memory_size is
// 0), the result is one word of totals and the unit then starts a new scan from address
// 0; only the last word of a scan waits for a result that is still waiting, and new
// words wait behind it for as long; the user writes configuration through write_enable/
// reg_index/write_data only while no scan word is in flight; the unit does not enforce it

module memory_occupancy_stats_unit
#(
    parameter int ADDR_BITS = 20
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      write_enable,
    input  logic [mos_pkg::REG_IDX_W-1:0] reg_index,
    input  logic [((ADDR_BITS + 1 > mos_pkg::PAGE_W) ? ADDR_BITS + 1 : mos_pkg::PAGE_W) - 1:0]
                                      write_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      allocated,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      status,
    output logic                      any_set,
    output logic [ADDR_BITS-1:0]      first_address,
    output logic signed [ADDR_BITS:0] last_address,
    output logic [ADDR_BITS:0]        byte_count,
    output logic [ADDR_BITS:0]        fill_count,
    output logic [ADDR_BITS:0]        page_count,
    output logic [ADDR_BITS:0]        section_count,
    output logic [ADDR_BITS:0]        trailing_count
);

    localparam int CW = ADDR_BITS + 1;

    logic [CW-1:0]      memory_size_reg;
    mos_pkg::page_off_t page_len_reg;
    logic [CW-1:0]      data_size_reg;

    logic advance;
    logic s1_valid;
    logic s1_alloc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_size_reg <= CW'(1) << (CW - 1);
            page_len_reg    <= mos_pkg::page_off_t'(1);
            data_size_reg   <= '0;
        end
        else if (write_enable)
        begin
            case (reg_index)
                mos_pkg::REG_MEMORY_SIZE: memory_size_reg <= write_data[CW-1:0];
                mos_pkg::REG_PAGE_LEN:    page_len_reg    <= write_data[mos_pkg::PAGE_W-1:0];
                mos_pkg::REG_DATA_SIZE:   data_size_reg   <= write_data[CW-1:0];
                default:                  ;
            endcase
        end
    end

    mos_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .allocated(allocated),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_alloc (s1_alloc)
    );

    mos_scan_core #(.ADDR_BITS(ADDR_BITS)) u_scan_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .memory_size   (memory_size_reg),
        .page_len      (page_len_reg),
        .data_size     (data_size_reg),
        .s1_valid      (s1_valid),
        .s1_alloc      (s1_alloc),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .any_set       (any_set),
        .first_address (first_address),
        .last_address  (last_address),
        .byte_count    (byte_count),
        .fill_count    (fill_count),
        .page_count    (page_count),
        .section_count (section_count),
        .trailing_count(trailing_count)
    );

endmodule

[tb/tb_memory_occupancy_stats_unit.sv]
`timescale 1ns / 1ps

module tb_memory_occupancy_stats_unit;

    localparam int AW = 20;
    localparam int CW = AW + 1;
    localparam int PW = mos_pkg::PAGE_W;
    localparam int IW = mos_pkg::REG_IDX_W;
    localparam int DW = (CW > PW) ? CW : PW;
    localparam logic [IW-1:0] REG_SPARE = 2'd3;
    localparam logic [CW-1:0] MEM_FULL = 21'd1048576;
    localparam logic [CW-1:0] SIZE_ALL_ONES = 21'h1FFFFF;
    localparam logic [PW-1:0] PAGE_LARGEST = 17'd65536;
    localparam logic [PW-1:0] PAGE_ALL_ONES = 17'h1FFFF;
    localparam int RANDOM_TAGS = 950;
    localparam int CALM_TAGS = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct {
        logic               status;
        logic               any_set;
        logic [AW-1:0]      first_address;
        logic signed [AW:0] last_address;
        logic [CW-1:0]      byte_count;
        logic [CW-1:0]      fill_count;
        logic [CW-1:0]      page_count;
        logic [CW-1:0]      section_count;
        logic [CW-1:0]      trailing_count;
    } occupancy_totals_t;

    typedef enum {TAGS_CLEAR, TAGS_SOLID, TAGS_RUNS, TAGS_NOISE} tag_pattern_t;

    class occupancy_scoreboard;
        logic [CW-1:0] mem_bytes;
        logic [PW-1:0] page_bytes;
        logic [CW-1:0] data_bytes;

        logic [CW-1:0]      byte_addr;
        mos_pkg::page_off_t page_off;
        logic               page_touched;
        logic               in_run;
        logic               seen_any;
        logic [AW-1:0]      first_addr;
        logic [CW-1:0]      last_addr;
        logic [CW-1:0]      n_bytes;
        logic [CW-1:0]      n_fill;
        logic [CW-1:0]      n_pages;
        logic [CW-1:0]      n_sections;
        logic [CW-1:0]      n_trailing;

        occupancy_totals_t expected_totals[$];
        int mismatch_count;

        function new();
            mem_bytes = MEM_FULL;
            page_bytes = PW'(1);
            data_bytes = '0;
            mismatch_count = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            byte_addr = '0;
            page_off = '0;
            page_touched = 1'b0;
            in_run = 1'b0;
            seen_any = 1'b0;
            first_addr = '0;
            last_addr = '1;
            n_bytes = '0;
            n_fill = '0;
            n_pages = '0;
            n_sections = '0;
            n_trailing = '0;
        endfunction

        function void set_register(logic [IW-1:0] idx, logic [DW-1:0] value);
            case (idx)
                mos_pkg::REG_MEMORY_SIZE: mem_bytes = value[CW-1:0];
                mos_pkg::REG_PAGE_LEN:    page_bytes = value[PW-1:0];
                mos_pkg::REG_DATA_SIZE:   data_bytes = value[CW-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_totals.size();
        endfunction

        function void note_tag(logic tag);
            logic [CW-1:0] addr;
            logic [PW-1:0] pg;
            occupancy_totals_t res;
            addr = byte_addr;
            pg = (page_bytes == '0) ? PW'(1) : page_bytes;
            if (tag) begin
                if (!seen_any) begin
                    seen_any = 1'b1;
                    first_addr = addr[AW-1:0];
                end
                last_addr = addr;
                if (addr < data_bytes) begin
                    n_bytes += CW'(1);
                    if (!page_touched) begin
                        page_touched = 1'b1;
                        n_fill += CW'(page_off);
                        n_pages += CW'(1);
                    end
                    if (!in_run) begin
                        in_run = 1'b1;
                        n_sections += CW'(1);
                    end
                end
                else begin
                    n_trailing += CW'(1);
                    if (page_touched)
                        n_fill += CW'(1);
                end
            end
            else begin
                in_run = 1'b0;
                if (page_touched)
                    n_fill += CW'(1);
            end
            page_off += mos_pkg::page_off_t'(1);
            if (page_off >= pg) begin
                page_off = '0;
                page_touched = 1'b0;
            end
            byte_addr += CW'(1);
            if (byte_addr < mem_bytes && byte_addr != '0)
                return;
            if (data_bytes > mem_bytes) begin
                res.status = 1'b1;
                res.any_set = 1'b0;
                res.first_address = '0;
                res.last_address = '1;
                res.byte_count = '0;
                res.fill_count = '0;
                res.page_count = '0;
                res.section_count = '0;
                res.trailing_count = '0;
            end
            else begin
                res.status = 1'b0;
                res.any_set = seen_any;
                res.first_address = first_addr;
                res.last_address = last_addr;
                res.byte_count = n_bytes;
                res.fill_count = n_fill;
                res.page_count = n_pages;
                res.section_count = n_sections;
                res.trailing_count = n_trailing;
            end
            expected_totals.push_back(res);
            clear_scan();
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        task compare_field(string field, logic signed [63:0] got, logic signed [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
        endtask

        task check_totals(occupancy_totals_t got);
            occupancy_totals_t want;
            if (expected_totals.size() == 0) begin
                report_mismatch("result word with no expectation waiting");
                return;
            end
            want = expected_totals.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("any_set", got.any_set, want.any_set);
            compare_field("first_address", got.first_address, want.first_address);
            compare_field("last_address", got.last_address, want.last_address);
            compare_field("byte_count", got.byte_count, want.byte_count);
            compare_field("fill_count", got.fill_count, want.fill_count);
            compare_field("page_count", got.page_count, want.page_count);
            compare_field("section_count", got.section_count, want.section_count);
            compare_field("trailing_count", got.trailing_count, want.trailing_count);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               write_enable;
    logic [IW-1:0]      reg_index;
    logic [DW-1:0]      write_data;
    logic               in_valid;
    logic               in_ready;
    logic               allocated;
    logic               out_valid;
    logic               out_ready;
    logic               status;
    logic               any_set;
    logic [AW-1:0]      first_address;
    logic signed [AW:0] last_address;
    logic [CW-1:0]      byte_count;
    logic [CW-1:0]      fill_count;
    logic [CW-1:0]      page_count;
    logic [CW-1:0]      section_count;
    logic [CW-1:0]      trailing_count;

    occupancy_scoreboard sb = new();
    logic         idle_on;
    logic         stall_on;
    int           tags_sent;
    tag_pattern_t tag_mode;
    logic         prev_tag;

    memory_occupancy_stats_unit #(
        .ADDR_BITS(AW)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .write_enable(write_enable),
        .reg_index(reg_index),
        .write_data(write_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .allocated(allocated),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .any_set(any_set),
        .first_address(first_address),
        .last_address(last_address),
        .byte_count(byte_count),
        .fill_count(fill_count),
        .page_count(page_count),
        .section_count(section_count),
        .trailing_count(trailing_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        occupancy_totals_t got;
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_tag(allocated);
            if (out_valid && out_ready) begin
                got.status = status;
                got.any_set = any_set;
                got.first_address = first_address;
                got.last_address = last_address;
                got.byte_count = byte_count;
                got.fill_count = fill_count;
                got.page_count = page_count;
                got.section_count = section_count;
                got.trailing_count = trailing_count;
                sb.check_totals(got);
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 3) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else begin
                out_ready = 1'b1;
            end
        end
    end

    function logic next_tag();
        case (tag_mode)
            TAGS_CLEAR: prev_tag = 1'b0;
            TAGS_SOLID: prev_tag = 1'b1;
            TAGS_RUNS:  prev_tag = ($urandom_range(0, 4) == 0) ? !prev_tag : prev_tag;
            default:    prev_tag = 1'($urandom_range(0, 1));
        endcase
        return prev_tag;
    endfunction

    task automatic send_tag(input logic tag);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        allocated = tag;
        do @(posedge clk); while (!in_ready);
        tags_sent++;
    endtask

    task automatic play_tags(input logic [31:0] bits, input int n);
        for (int i = 0; i < n; i++)
            send_tag(bits[i]);
    endtask

    // no word in flight and every result delivered before a register write
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] value);
        @(negedge clk);
        write_enable = 1'b1;
        reg_index = idx;
        write_data = value;
        sb.set_register(idx, value);
        @(negedge clk);
        write_enable = 1'b0;
    endtask

    initial
    begin
        int random_start;
        int count;
        int bound;
        int waited;
        bit first_phase;
        bit calm;
        logic [CW-1:0] mem_pick;
        logic [CW-1:0] data_pick;
        logic [PW-1:0] page_pick;

        rst_n = 1'b0;
        in_valid = 1'b0;
        allocated = 1'b0;
        write_enable = 1'b0;
        reg_index = mos_pkg::REG_MEMORY_SIZE;
        write_data = '0;
        idle_on = 1'b1;
        stall_on = 1'b1;
        tags_sent = 0;
        tag_mode = TAGS_RUNS;
        prev_tag = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero page size
        settle();
        write_reg(mos_pkg::REG_MEMORY_SIZE, DW'(6));
        write_reg(mos_pkg::REG_PAGE_LEN, DW'(0));
        write_reg(mos_pkg::REG_DATA_SIZE, DW'(6));
        play_tags(32'b110110, 6);

        // trailing bytes and a partial last page
        settle();
        write_reg(mos_pkg::REG_PAGE_LEN, DW'(4));
        write_reg(mos_pkg::REG_DATA_SIZE, DW'(3));
        play_tags(32'b101111, 6);

        // data size beyond memory size
        settle();
        write_reg(mos_pkg::REG_MEMORY_SIZE, DW'(3));
        write_reg(mos_pkg::REG_PAGE_LEN, DW'(2));
        write_reg(mos_pkg::REG_DATA_SIZE, DW'(5));
        play_tags(32'b101, 3);

        // zero memory size
        settle();
        write_reg(mos_pkg::REG_MEMORY_SIZE, DW'(0));
        write_reg(mos_pkg::REG_DATA_SIZE, DW'(0));
        play_tags(32'b1, 1);

        // largest sizes, then memory shrunk below the current address
        settle();
        write_reg(mos_pkg::REG_MEMORY_SIZE, DW'(MEM_FULL));
        write_reg(mos_pkg::REG_PAGE_LEN, DW'(PAGE_LARGEST));
        write_reg(mos_pkg::REG_DATA_SIZE, DW'(SIZE_ALL_ONES));
        play_tags(32'b101, 3);
        settle();
        write_reg(mos_pkg::REG_PAGE_LEN, DW'(PAGE_ALL_ONES));
        write_reg(mos_pkg::REG_DATA_SIZE, DW'(2));
        write_reg(mos_pkg::REG_MEMORY_SIZE, DW'(2));
        play_tags(32'b1, 1);

        // trailing byte inside a run, then data size raised mid-scan
        settle();
        write_reg(REG_SPARE, DW'(SIZE_ALL_ONES));
        write_reg(mos_pkg::REG_MEMORY_SIZE, DW'(8));
        write_reg(mos_pkg::REG_PAGE_LEN, DW'(3));
        write_reg(mos_pkg::REG_DATA_SIZE, DW'(2));
        play_tags(32'b111, 3);
        settle();
        write_reg(mos_pkg::REG_DATA_SIZE, DW'(8));
        play_tags(32'b11101, 5);

        random_start = tags_sent;
        first_phase = 1'b1;
        while (tags_sent - random_start < RANDOM_TAGS) begin
            calm = (tags_sent - random_start >= RANDOM_TAGS - CALM_TAGS);
            if (!calm) begin
                settle();
                idle_on = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 19))
                    0: mem_pick = CW'($urandom_range(0, 1));
                    1: mem_pick = $urandom_range(0, 1) ? MEM_FULL : SIZE_ALL_ONES;
                    default: mem_pick = CW'($urandom_range(1, 40));
                endcase
                case ($urandom_range(0, 9))
                    0: page_pick = PAGE_LARGEST;
                    1: page_pick = $urandom_range(0, 1) ? PAGE_ALL_ONES : PW'($urandom);
                    default: page_pick = PW'($urandom_range(0, 9));
                endcase
                case ($urandom_range(0, 9))
                    0: data_pick = SIZE_ALL_ONES;
                    1: data_pick = MEM_FULL;
                    default: data_pick = CW'($urandom_range(0,
                        (mem_pick > 40) ? 64 : int'(mem_pick) + 2));
                endcase
                if (first_phase || $urandom_range(0, 2) != 0)
                    write_reg(mos_pkg::REG_MEMORY_SIZE, DW'(mem_pick));
                if (first_phase || $urandom_range(0, 2) != 0)
                    write_reg(mos_pkg::REG_PAGE_LEN, DW'(page_pick));
                if (first_phase || $urandom_range(0, 2) != 0)
                    write_reg(mos_pkg::REG_DATA_SIZE, DW'(data_pick));
                if ($urandom_range(0, 9) == 0)
                    write_reg(REG_SPARE, DW'($urandom));
                first_phase = 1'b0;
            end
            else begin
                idle_on = 1'b0;
                stall_on = 1'b0;
            end
            case ($urandom_range(0, 19))
                0, 1, 2:    tag_mode = TAGS_CLEAR;
                3, 4, 5:    tag_mode = TAGS_SOLID;
                6, 7, 8, 9: tag_mode = TAGS_NOISE;
                default:    tag_mode = TAGS_RUNS;
            endcase
            bound = (sb.mem_bytes == 0 || sb.mem_bytes > 40) ? 60 : 3 * int'(sb.mem_bytes);
            count = $urandom_range(1, bound);
            repeat (count) send_tag(next_tag());
        end

        @(negedge clk);
        in_valid = 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("tb_memory_occupancy_stats_unit: PASS");
        else
            $display("tb_memory_occupancy_stats_unit: FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_memory_occupancy_stats_unit: FAIL");
        $finish;
    end

endmodule

[memory_occupancy_stats_unit.f]
rtl/mos_pkg.sv
rtl/mos_in_stage.sv
rtl/mos_scan_core.sv
rtl/memory_occupancy_stats_unit.sv
tb/tb_memory_occupancy_stats_unit.sv
